### src/brb_pkg.sv
// Shared types and codes for the byte ring buffer unit.
// Used by brb_byte_ram, brb_ptr_ctrl and byte_ring_buffer_unit; depends on nothing.
package brb_pkg;

    // Operation codes carried by a request.
    localparam logic [2:0] OP_PUT     = 3'd0;
    localparam logic [2:0] OP_GET     = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_DISCARD = 3'd3;
    localparam logic [2:0] OP_COMMIT  = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // One request.
    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte_in;
        logic [9:0] count;
        logic [9:0] peek_offset;
    } req_t;

    // One result.
    typedef struct packed {
        logic [7:0] data_byte_out;
        logic [1:0] status;
        logic [9:0] moved_count;
        logic [9:0] used_count;
        logic [9:0] free_count;
    } rsp_t;

    // Byte store access strobes.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

### src/brb_byte_ram.sv
// Single-port byte store with a registered read port.
// Depends on brb_pkg for the access strobe type.
module brb_byte_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  brb_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // One write or one read per cycle; read data is registered.
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/brb_ptr_ctrl.sv
// Read and write pointers, used/free accounting and the per-request decision.
// Depends on brb_pkg for request, result and access strobe types.
module brb_ptr_ctrl #(
    parameter int DEPTH = 1024,
    parameter int GAP   = 1,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  brb_pkg::req_t     req,
    output brb_pkg::mem_ctl_t mem_ctl,
    output logic [AW-1:0]     mem_addr,
    output brb_pkg::rsp_t     rsp,
    output logic              rd_hit
);

    // Wide enough for any count field and for DEPTH itself.
    localparam int NW = ((AW > 10) ? AW : 10) + 1;
    localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);
    localparam logic [AW:0] CAP_V   = (AW+1)'(DEPTH - GAP);

    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;

    logic [AW:0]   used_now;
    logic [AW:0]   free_now;
    logic [AW:0]   used_after;
    logic [AW:0]   free_after;
    logic [NW-1:0] cnt_w;
    logic [NW-1:0] off_w;
    logic [NW-1:0] used_w;
    logic [NW-1:0] free_w;
    logic [NW-1:0] used_after_w;
    logic [NW-1:0] free_after_w;
    logic [NW-1:0] moved_w;
    logic [AW:0]   cnt_n;
    logic [AW-1:0] rp_cnt;
    logic [AW-1:0] wp_cnt;
    logic [AW-1:0] rp_one;
    logic [AW-1:0] wp_one;
    logic [AW-1:0] peek_addr;
    logic [1:0]    status;
    logic          do_we;
    logic          do_re;

    // Pointer advance with a single wraparound correction.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [AW:0] n);
        logic [AW+1:0] s;
        s = {2'b00, p} + {1'b0, n};
        if (s >= {1'b0, DEPTH_V})
        begin
            s = s - {1'b0, DEPTH_V};
        end
        return s[AW-1:0];
    endfunction

    // Free space for a given fill level.
    function automatic logic [AW:0] free_of(input logic [AW:0] u);
        return (u >= CAP_V) ? '0 : (CAP_V - u);
    endfunction

    // Fill level before the request.
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            used_now = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            used_now = DEPTH_V + {1'b0, wp_reg} - {1'b0, rp_reg};
        end
    end

    assign free_now = free_of(used_now);
    assign cnt_w    = NW'(req.count);
    assign off_w    = NW'(req.peek_offset);
    assign used_w   = NW'(used_now);
    assign free_w   = NW'(free_now);
    assign cnt_n    = cnt_w[AW:0];

    // Candidate pointer positions.
    assign rp_one    = advance(rp_reg, (AW+1)'(1));
    assign wp_one    = advance(wp_reg, (AW+1)'(1));
    assign rp_cnt    = advance(rp_reg, cnt_n);
    assign wp_cnt    = advance(wp_reg, cnt_n);
    assign peek_addr = advance(rp_reg, off_w[AW:0]);

    // Decide the outcome of the request.
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        status     = brb_pkg::ST_OK;
        moved_w    = '0;
        used_after = used_now;
        do_we      = 1'b0;
        do_re      = 1'b0;
        mem_addr   = wp_reg;
        case (req.operation)
            brb_pkg::OP_PUT:
            begin
                if (free_now == '0)
                begin
                    status = brb_pkg::ST_FULL;
                end
                else
                begin
                    do_we      = 1'b1;
                    wp_next    = wp_one;
                    moved_w    = NW'(1);
                    used_after = used_now + (AW+1)'(1);
                end
            end
            brb_pkg::OP_GET:
            begin
                mem_addr = rp_reg;
                if (used_now == '0)
                begin
                    status = brb_pkg::ST_EMPTY;
                end
                else
                begin
                    do_re      = 1'b1;
                    rp_next    = rp_one;
                    moved_w    = NW'(1);
                    used_after = used_now - (AW+1)'(1);
                end
            end
            brb_pkg::OP_PEEK:
            begin
                mem_addr = peek_addr;
                if (used_now == '0)
                begin
                    status = brb_pkg::ST_EMPTY;
                end
                else if (off_w >= used_w)
                begin
                    status = brb_pkg::ST_RANGE;
                end
                else
                begin
                    do_re   = 1'b1;
                    moved_w = NW'(1);
                end
            end
            brb_pkg::OP_DISCARD:
            begin
                if (cnt_w > used_w)
                begin
                    status = brb_pkg::ST_RANGE;
                end
                else
                begin
                    rp_next    = rp_cnt;
                    moved_w    = cnt_w;
                    used_after = used_now - cnt_n;
                end
            end
            brb_pkg::OP_COMMIT:
            begin
                if (cnt_w > free_w)
                begin
                    status = brb_pkg::ST_RANGE;
                end
                else
                begin
                    wp_next    = wp_cnt;
                    moved_w    = cnt_w;
                    used_after = used_now + cnt_n;
                end
            end
            brb_pkg::OP_CLEAR:
            begin
                rp_next    = '0;
                wp_next    = '0;
                used_after = '0;
            end
            default:
            begin
                // Unused codes leave everything as it is.
            end
        endcase
    end

    assign free_after   = free_of(used_after);
    assign used_after_w = NW'(used_after);
    assign free_after_w = NW'(free_after);

    // Result fields; the read byte is merged in by the top level.
    always_comb
    begin
        rsp               = '0;
        rsp.status        = status;
        rsp.moved_count   = moved_w[9:0];
        rsp.used_count    = used_after_w[9:0];
        rsp.free_count    = free_after_w[9:0];
    end

    assign mem_ctl.we = accept & do_we;
    assign mem_ctl.re = accept & do_re;
    assign rd_hit     = do_re;

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg <= '0;
            wp_reg <= '0;
        end
        else if (accept)
        begin
            rp_reg <= rp_next;
            wp_reg <= wp_next;
        end
    end

endmodule

### src/byte_ring_buffer_unit.sv
// Top level of the byte ring buffer: request decode, byte store and result stage.
// Depends on brb_pkg, brb_ptr_ctrl and brb_byte_ram.

// A request is taken at every clock edge with start high; busy never rises, so one
// request per cycle is sustained. Each request produces exactly one result, shown on
// result with done high for one cycle, in the cycle after the request was taken; the
// receiver cannot hold it off, and successive results follow at the request rate.
// The rate rests on the single-port byte store: every request makes at most one
// access to it, and its registered read port lines up with the result stage registers.
// A byte written by a put is visible to a get or peek in the very next request.
// There is no clearing pass after reset; bytes that were committed but never written
// read back as whatever the store holds.
module byte_ring_buffer_unit #(
    parameter int DEPTH = 1024,
    parameter int GAP   = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  brb_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output brb_pkg::rsp_t result
);

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    brb_pkg::mem_ctl_t mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_rdata;
    brb_pkg::rsp_t     rsp;
    logic              rd_hit;

    brb_pkg::rsp_t     rsp_reg;
    logic              rd_reg;
    logic              done_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Pointer control and decision logic.
    brb_ptr_ctrl #(
        .DEPTH (DEPTH),
        .GAP   (GAP),
        .AW    (AW)
    ) u_ptr_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .rsp      (rsp),
        .rd_hit   (rd_hit)
    );

    // Byte store.
    brb_byte_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_byte_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (req.data_byte_in),
        .rdata (mem_rdata)
    );

    // Result stage strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Result stage payload, aligned with the store's read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp;
            rd_reg  <= rd_hit;
        end
    end

    // Merge the read byte into the result.
    always_comb
    begin
        result               = rsp_reg;
        result.data_byte_out = rd_reg ? mem_rdata : 8'd0;
    end

    assign done = done_reg;

endmodule

### test/brb_result_checker.sv
// Result checker for the byte ring buffer unit: mirrors the ring state, predicts one
// result per accepted request and compares it with what the block reports.
// Depends on brb_pkg only.
module brb_result_checker #(
    parameter int DEPTH = 1024,
    parameter int GAP   = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  brb_pkg::req_t req,
    input  logic          done,
    input  brb_pkg::rsp_t result,
    output int            fail_count,
    output int            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    // Mirror of the ring: byte store plus the two pointers.
    logic [7:0]  ring_bytes [DEPTH];
    int          head_at;
    int          tail_at;
    rsp_t        due_results [$];

    function automatic int bytes_held();
        return (tail_at + DEPTH - head_at) % DEPTH;
    endfunction

    function automatic int bytes_room();
        int cap;
        int held;
        cap  = DEPTH - GAP;
        held = bytes_held();
        return (held >= cap) ? 0 : cap - held;
    endfunction

    // Apply one request to the mirror and return the result it must produce.
    function automatic rsp_t ring_outcome(input req_t r);
        rsp_t o;
        int   held;
        int   amount;
        int   offset;
        o       = '0;
        o.status = ST_OK;
        held    = bytes_held();
        amount  = int'(r.count);
        offset  = int'(r.peek_offset);
        case (r.operation)
            OP_PUT:
            begin
                if (bytes_room() == 0)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    ring_bytes[tail_at] = r.data_byte_in;
                    tail_at = (tail_at + 1) % DEPTH;
                    o.moved_count = 10'd1;
                end
            end
            OP_GET:
            begin
                if (held == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    o.data_byte_out = ring_bytes[head_at];
                    head_at = (head_at + 1) % DEPTH;
                    o.moved_count = 10'd1;
                end
            end
            OP_PEEK:
            begin
                if (held == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else if (offset >= held)
                begin
                    o.status = ST_RANGE;
                end
                else
                begin
                    o.data_byte_out = ring_bytes[(head_at + offset) % DEPTH];
                    o.moved_count = 10'd1;
                end
            end
            OP_DISCARD:
            begin
                if (amount > held)
                begin
                    o.status = ST_RANGE;
                end
                else
                begin
                    head_at = (head_at + amount) % DEPTH;
                    o.moved_count = r.count;
                end
            end
            OP_COMMIT:
            begin
                if (amount > bytes_room())
                begin
                    o.status = ST_RANGE;
                end
                else
                begin
                    tail_at = (tail_at + amount) % DEPTH;
                    o.moved_count = r.count;
                end
            end
            OP_CLEAR:
            begin
                head_at = 0;
                tail_at = 0;
            end
            default:
            begin
            end
        endcase
        o.used_count = 10'(bytes_held());
        o.free_count = 10'(bytes_room());
        return o;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Compare each strobed result with the oldest prediction, then record the
    // prediction for a request taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            head_at = 0;
            tail_at = 0;
            due_results.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request pending, expected none, actual %p",
                             $time, result);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("data_byte_out", want.data_byte_out, result.data_byte_out);
                    check_field("status", want.status, result.status);
                    check_field("moved_count", want.moved_count, result.moved_count);
                    check_field("used_count", want.used_count, result.used_count);
                    check_field("free_count", want.free_count, result.free_count);
                end
            end
            if (start && !busy)
            begin
                due_results.push_back(ring_outcome(req));
            end
            outstanding <= due_results.size();
        end
    end

endmodule

### test/tb_byte_ring_buffer_unit.sv
// Testbench top for byte_ring_buffer_unit: drives directed and random requests in
// bursts and gives the verdict. Depends on brb_pkg, the block and brb_result_checker.
module tb_byte_ring_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    localparam int         DEPTH       = 1024;
    localparam int         GAP         = 1;
    localparam int         CLK_PERIOD  = 10;
    localparam int         ITEM_TARGET = 1950;
    localparam int         IDLE_LIMIT  = 1000;
    localparam int         TAIL_CYCLES = 4;
    // Operation codes the block leaves unused.
    localparam logic [2:0] OP_SPARE_A  = 3'd6;
    localparam logic [2:0] OP_SPARE_B  = 3'd7;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    req_t  req;
    logic  busy;
    logic  done;
    rsp_t  result;
    int    fail_count;
    int    outstanding;
    int    idle_cycles = 0;

    // Stimulus-side bookkeeping: pointers and which store slots hold a real byte,
    // so that no get or peek ever lands on a slot that was never written.
    int    rd_at = 0;
    int    wr_at = 0;
    bit    byte_written [DEPTH];
    int    sent_items = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    byte_ring_buffer_unit #(
        .DEPTH (DEPTH),
        .GAP   (GAP)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    brb_result_checker #(
        .DEPTH (DEPTH),
        .GAP   (GAP)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic int level_now();
        return (wr_at + DEPTH - rd_at) % DEPTH;
    endfunction

    function automatic int space_now();
        int lvl;
        lvl = level_now();
        return (lvl >= DEPTH - GAP) ? 0 : DEPTH - GAP - lvl;
    endfunction

    function automatic req_t mk(input logic [2:0] op, input logic [7:0] data,
                                input logic [9:0] cnt, input logic [9:0] offset);
        req_t r;
        r.operation    = op;
        r.data_byte_in = data;
        r.count        = cnt;
        r.peek_offset  = offset;
        return r;
    endfunction

    // Advance the bookkeeping for a request the block has taken.
    function automatic void note_accepted(input req_t r);
        int lvl;
        int spc;
        lvl = level_now();
        spc = space_now();
        case (r.operation)
            OP_PUT:
            begin
                if (spc > 0)
                begin
                    byte_written[wr_at] = 1'b1;
                    wr_at = (wr_at + 1) % DEPTH;
                end
            end
            OP_GET:
            begin
                if (lvl > 0)
                    rd_at = (rd_at + 1) % DEPTH;
            end
            OP_DISCARD:
            begin
                if (int'(r.count) <= lvl)
                    rd_at = (rd_at + int'(r.count)) % DEPTH;
            end
            OP_COMMIT:
            begin
                if (int'(r.count) <= spc)
                    wr_at = (wr_at + int'(r.count)) % DEPTH;
            end
            OP_CLEAR:
            begin
                rd_at = 0;
                wr_at = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Operation mix per burst: fill-heavy, drain-heavy or mixed.
    function automatic logic [2:0] pick_op(input int mode);
        int roll;
        int cut [7];
        roll = $urandom_range(99);
        case (mode)
            0:       cut = '{70, 80, 90, 95, 98, 99, 100};
            1:       cut = '{10, 70, 85, 95, 98, 99, 100};
            default: cut = '{30, 55, 75, 85, 95, 98, 100};
        endcase
        if (roll < cut[0]) return OP_PUT;
        if (roll < cut[1]) return OP_GET;
        if (roll < cut[2]) return OP_PEEK;
        if (roll < cut[3]) return OP_DISCARD;
        if (roll < cut[4]) return OP_COMMIT;
        if (roll < cut[5]) return OP_CLEAR;
        return ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    // Random request of the given kind; counts and offsets lean toward the
    // boundaries of the current fill level, with some full-range values.
    function automatic req_t shape_req(input logic [2:0] op);
        req_t r;
        int   lvl;
        int   spc;
        lvl = level_now();
        spc = space_now();
        r   = mk(op, 8'($urandom), 10'($urandom), 10'($urandom));
        case (op)
            OP_GET:
            begin
                // A slot reached only by commit holds no real byte: skip it instead.
                if (lvl > 0 && !byte_written[rd_at])
                begin
                    r.operation = OP_DISCARD;
                    r.count     = 10'd1;
                end
            end
            OP_PEEK:
            begin
                if (lvl > 0 && $urandom_range(9) < 7)
                    r.peek_offset = 10'($urandom_range(lvl - 1));
                if (lvl > 0 && int'(r.peek_offset) < lvl
                        && !byte_written[(rd_at + int'(r.peek_offset)) % DEPTH])
                    r.peek_offset = 10'(lvl);
            end
            OP_DISCARD:
            begin
                if ($urandom_range(3) != 0)
                    r.count = 10'($urandom_range((lvl + 2 > 1023) ? 1023 : lvl + 2));
            end
            OP_COMMIT:
            begin
                if ($urandom_range(3) != 0)
                    r.count = 10'($urandom_range((spc + 2 > 1023) ? 1023 : spc + 2));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        note_accepted(r);
        if (r.operation != OP_SPARE_A && r.operation != OP_SPARE_B)
            sent_items++;
    endtask

    // Watchdog: too long without a request taken or a result shown ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int mode;
        int burst;
        int gap;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty, full and out-of-range cases, zero counts,
        // clear, the unused codes and the extreme field values.
        send(mk(OP_GET,     8'h00, 10'd0,    10'd0));
        send(mk(OP_PEEK,    8'h00, 10'd0,    10'd0));
        send(mk(OP_DISCARD, 8'h00, 10'd0,    10'd0));
        send(mk(OP_DISCARD, 8'h00, 10'd1,    10'd0));
        send(mk(OP_COMMIT,  8'h00, 10'd0,    10'd0));
        send(mk(OP_PUT,     8'h00, 10'd0,    10'd0));
        send(mk(OP_PUT,     8'hFF, 10'd1023, 10'd1023));
        send(mk(OP_PEEK,    8'h00, 10'd0,    10'd1));
        send(mk(OP_PEEK,    8'h00, 10'd0,    10'd2));
        send(mk(OP_PEEK,    8'h00, 10'd0,    10'd1023));
        send(mk(OP_GET,     8'h00, 10'd0,    10'd0));
        send(mk(OP_SPARE_A, 8'hFF, 10'd1023, 10'd1023));
        send(mk(OP_SPARE_B, 8'h00, 10'd0,    10'd0));
        send(mk(OP_COMMIT,  8'h00, 10'd1023, 10'd0));
        send(mk(OP_COMMIT,  8'h00, 10'd1022, 10'd0));
        send(mk(OP_PUT,     8'h5A, 10'd0,    10'd0));
        send(mk(OP_COMMIT,  8'h00, 10'd1,    10'd0));
        send(mk(OP_PEEK,    8'h00, 10'd0,    10'd0));
        send(mk(OP_DISCARD, 8'h00, 10'd1023, 10'd0));
        send(mk(OP_DISCARD, 8'h00, 10'd1,    10'd0));
        send(mk(OP_GET,     8'h00, 10'd0,    10'd0));
        send(mk(OP_CLEAR,   8'h00, 10'd0,    10'd0));
        send(mk(OP_COMMIT,  8'h00, 10'd1023, 10'd0));
        send(mk(OP_CLEAR,   8'h00, 10'd0,    10'd0));
        send(mk(OP_PUT,     8'hA5, 10'd0,    10'd0));

        // Random part: bursts of requests with random gaps between them.
        while (sent_items < ITEM_TARGET)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
                send(shape_req(pick_op(mode)));
            gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        // Drain the remaining results, then allow the block's latency.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
